@@ hdl/sfss_pkg.sv @@
// Shared types, constants and helper functions of the full-step sequencer.
`default_nettype none

package sfss_pkg;

   localparam int POSITION_WIDTH_DEFAULT = 32;

   localparam int TIME_WIDTH     = 32;
   localparam int MIN_IV_WIDTH   = 27;
   localparam int LEVEL_WIDTH    = 6;
   localparam int CSR_DATA_WIDTH = 27;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [MIN_IV_WIDTH-1:0] MIN_INTERVAL_RESET = 27'd5000;
   localparam logic [LEVEL_WIDTH-1:0]  DRIVE_LEVEL_RESET  = 6'd30;

   typedef enum logic [2:0] {
      KIND_POLL         = 3'd0,
      KIND_SET_MOTION   = 3'd1,
      KIND_STOP         = 3'd2,
      KIND_HOLD         = 3'd3,
      KIND_RELEASE      = 3'd4,
      KIND_SET_POSITION = 3'd5
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_INTERVAL = 2'd0,
      CSR_DRIVE_LEVEL  = 2'd1,
      CSR_DIR_INVERTED = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DRIVE_COAST = 2'd0,
      DRIVE_NEG   = 2'd1,
      DRIVE_POS   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [1:0]            phase;
      logic [TIME_WIDTH-1:0] interval;
      logic                  reverse;
      logic [TIME_WIDTH-1:0] next_due;
      logic                  released;
   } motor_state_type;

   typedef struct packed {
      logic [MIN_IV_WIDTH-1:0] min_interval;
      logic [LEVEL_WIDTH-1:0]  level;
      logic                    inverted;
   } config_type;

   typedef struct packed {
      logic [7:0] bridge_a;
      logic [7:0] bridge_b;
      logic       write_bridges;
      logic       stepped;
   } step_result_type;

   // A nonzero interval below the floor is raised to it; a floor of zero acts as one.
   function automatic logic [TIME_WIDTH-1:0] floor_interval(
      input logic [TIME_WIDTH-1:0]   iv,
      input logic [MIN_IV_WIDTH-1:0] min_iv
   );
      logic [TIME_WIDTH-1:0] lo;
      lo = (min_iv == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(min_iv);
      return (iv != '0 && iv < lo) ? lo : iv;
   endfunction

   function automatic mode_type bridge_a_mode(input logic [1:0] phase);
      mode_type m;
      case (phase)
         2'd0:    m = DRIVE_POS;
         2'd1:    m = DRIVE_NEG;
         2'd2:    m = DRIVE_NEG;
         default: m = DRIVE_POS;
      endcase
      return m;
   endfunction

   function automatic mode_type bridge_b_mode(input logic [1:0] phase);
      mode_type m;
      case (phase)
         2'd0:    m = DRIVE_POS;
         2'd1:    m = DRIVE_POS;
         2'd2:    m = DRIVE_NEG;
         default: m = DRIVE_NEG;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ hdl/sfss_step.sv @@
// Next-state and bridge-byte logic for one request of the full-step sequencer.
`default_nettype none

module sfss_step #(
   parameter int POSITION_WIDTH = sfss_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire sfss_pkg::motor_state_type cur_state,
   input  wire [POSITION_WIDTH-1:0]       cur_position,
   input  wire sfss_pkg::config_type      cfg,
   input  wire [2:0]                      kind,
   input  wire [31:0]                     now_us,
   input  wire [31:0]                     interval_us,
   input  wire                            move_reverse,
   input  wire signed [31:0]              position_value,
   output sfss_pkg::motor_state_type      nxt_state,
   output logic [POSITION_WIDTH-1:0]      nxt_position,
   output sfss_pkg::step_result_type      result
);

   logic [31:0] since_due;
   logic [31:0] cand_due;
   logic [31:0] since_cand;
   logic [31:0] floored_iv;
   logic [31:0] remaining;
   logic        due;
   logic        phase_back;
   logic        was_stopped;
   logic        will_stop;
   logic        reversed;

   always_comb begin
      since_due   = now_us - cur_state.next_due;
      due         = (cur_state.interval != '0) && !since_due[31];
      phase_back  = cur_state.reverse ^ cfg.inverted;
      cand_due    = cur_state.next_due + cur_state.interval;
      since_cand  = now_us - cand_due;
      floored_iv  = sfss_pkg::floor_interval(interval_us, cfg.min_interval);
      remaining   = cur_state.next_due - now_us;
      was_stopped = (cur_state.interval == '0);
      will_stop   = (floored_iv == '0);
      reversed    = !was_stopped && !will_stop && (cur_state.reverse != move_reverse);
   end

   always_comb begin
      nxt_state            = cur_state;
      nxt_position         = cur_position;
      result.write_bridges = 1'b0;
      result.stepped       = 1'b0;
      case (kind)
         sfss_pkg::KIND_POLL: begin
            if (due) begin
               nxt_state.phase    = cur_state.phase + (phase_back ? 2'd3 : 2'd1);
               nxt_state.released = 1'b0;
               nxt_position       = cur_position +
                                    (cur_state.reverse ? {POSITION_WIDTH{1'b1}}
                                                       : POSITION_WIDTH'(1));
               // A late poll restarts the schedule from now instead of catching up.
               nxt_state.next_due = !since_cand[31] ? now_us + cur_state.interval
                                                    : cand_due;
               result.write_bridges = 1'b1;
               result.stepped       = 1'b1;
            end
         end
         sfss_pkg::KIND_SET_MOTION: begin
            nxt_state.interval = floored_iv;
            if (will_stop) begin
               nxt_state.reverse = 1'b0;
            end else begin
               nxt_state.reverse = move_reverse;
               if (was_stopped || reversed) begin
                  nxt_state.next_due = now_us;
               end else if (remaining != '0 && !remaining[31] && remaining > floored_iv) begin
                  nxt_state.next_due = now_us + floored_iv;
               end
            end
         end
         sfss_pkg::KIND_STOP: begin
            nxt_state.interval = '0;
            nxt_state.reverse  = 1'b0;
         end
         sfss_pkg::KIND_HOLD: begin
            nxt_state.interval   = '0;
            nxt_state.reverse    = 1'b0;
            nxt_state.released   = 1'b0;
            result.write_bridges = 1'b1;
         end
         sfss_pkg::KIND_RELEASE: begin
            nxt_state.interval   = '0;
            nxt_state.reverse    = 1'b0;
            nxt_state.released   = 1'b1;
            result.write_bridges = 1'b1;
         end
         sfss_pkg::KIND_SET_POSITION: begin
            nxt_position = POSITION_WIDTH'(position_value);
         end
         default: begin
         end
      endcase

      // Released coils read as coast at level zero on both bridges.
      if (nxt_state.released) begin
         result.bridge_a = '0;
         result.bridge_b = '0;
      end else begin
         result.bridge_a = {cfg.level, sfss_pkg::bridge_a_mode(nxt_state.phase)};
         result.bridge_b = {cfg.level, sfss_pkg::bridge_b_mode(nxt_state.phase)};
      end
   end

endmodule

`default_nettype wire

@@ hdl/stepper_full_step_sequencer_unit.sv @@
// Top level of the two-phase full-step sequencer with H-bridge control outputs.
// An accepted request's response is loaded into the output register at the accepting edge.
// One request per cycle while req_stall is low; the motor state updates at the accepting edge.
// req_stall is high only while a response is held and rsp_stall is high.
// Synchronous active-high reset: coils released, stopped, position and phase zero,
// min interval 5000 us, drive level 30, direction not inverted, no response pending.
`default_nettype none

module stepper_full_step_sequencer_unit #(
   parameter int POSITION_WIDTH = sfss_pkg::POSITION_WIDTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write,
   input  wire [sfss_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [sfss_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire [2:0]                              req_kind,
   input  wire [31:0]                             req_now_us,
   input  wire [31:0]                             req_interval_us,
   input  wire                                    req_move_reverse,
   input  wire signed [31:0]                      req_position_value,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [7:0]                             rsp_bridge_a_control,
   output logic [7:0]                             rsp_bridge_b_control,
   output logic                                   rsp_write_bridges,
   output logic                                   rsp_stepped,
   output logic signed [31:0]                     rsp_position_now,
   output logic                                   rsp_running,
   output logic                                   rsp_energized
);

   sfss_pkg::motor_state_type state_ff, state_in;
   sfss_pkg::config_type      cfg_ff;
   sfss_pkg::step_result_type result_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic                      rsp_valid_ff;
   logic                      req_accept;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;

   sfss_step #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_step (
      .cur_state     (state_ff),
      .cur_position  (position_ff),
      .cfg           (cfg_ff),
      .kind          (req_kind),
      .now_us        (req_now_us),
      .interval_us   (req_interval_us),
      .move_reverse  (req_move_reverse),
      .position_value(req_position_value),
      .nxt_state     (state_in),
      .nxt_position  (position_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= 2'd0;
         state_ff.interval     <= '0;
         state_ff.reverse      <= 1'b0;
         state_ff.next_due     <= '0;
         state_ff.released     <= 1'b1;
         position_ff           <= '0;
         cfg_ff.min_interval   <= sfss_pkg::MIN_INTERVAL_RESET;
         cfg_ff.level          <= sfss_pkg::DRIVE_LEVEL_RESET;
         cfg_ff.inverted       <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff    <= state_in;
            position_ff <= position_in;
         end else if (csr_write && csr_index == sfss_pkg::CSR_MIN_INTERVAL) begin
            // Unless a request is accepted, a new floor also raises a running interval that now lies below it.
            state_ff.interval <= sfss_pkg::floor_interval(state_ff.interval,
                                                          csr_data);
         end
         if (csr_write) begin
            case (csr_index)
               sfss_pkg::CSR_MIN_INTERVAL: cfg_ff.min_interval <= csr_data;
               sfss_pkg::CSR_DRIVE_LEVEL:
                  cfg_ff.level <= csr_data[sfss_pkg::LEVEL_WIDTH-1:0];
               sfss_pkg::CSR_DIR_INVERTED: cfg_ff.inverted <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload; loaded only when a request is accepted.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_bridge_a_control <= result_in.bridge_a;
         rsp_bridge_b_control <= result_in.bridge_b;
         rsp_write_bridges    <= result_in.write_bridges;
         rsp_stepped          <= result_in.stepped;
         rsp_position_now     <= 32'(signed'(position_in));
         rsp_running          <= (state_in.interval != '0);
         rsp_energized        <= !state_in.released;
      end
   end

endmodule

`default_nettype wire
